[src/tlvp_pkg.sv]
// Shared types, constants and the magic header table for the TLV block parser.
// No dependencies; every other file except tlvp_if imports this package.
`timescale 1ns / 1ps

package tlvp_pkg;

  // Header length in bytes and width of the buffer position counter
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned POS_BITS     = 32;
  localparam int unsigned MAGIC_BYTES  = 16;
  localparam int unsigned OFFSET_BITS  = 32;

  // Result queue depth (a final byte can push a block result and a status)
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAG     = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_BLOCK  = 2'd0,
    EV_OK     = 2'd1,
    EV_HEADER = 2'd2,
    EV_TRUNC  = 2'd3
  } event_e;

  // One result item
  typedef struct packed {
    event_e                  kind;
    logic signed [63:0]      tag;
    logic [63:0]             length;
    logic [OFFSET_BITS-1:0]  offset;
    logic                    final_res;
  } res_t;

  // Push request from the parser datapath into the result queue
  typedef struct packed {
    logic [1:0] cnt;    // 0, 1 or 2 results this cycle
    res_t       first;
    res_t       second;
  } rq_push_t;

  // Magic pattern: "Armageddon" followed by 6, 6, 6, 42, 30, 0
  localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
    8'h41, 8'h72, 8'h6d, 8'h61, 8'h67, 8'h65, 8'h64, 8'h64,
    8'h6f, 8'h6e, 8'd6,  8'd6,  8'd6,  8'd42, 8'd30, 8'd0
  };

endpackage

[src/tlvp_if.sv]
// Stream channel interfaces for the TLV block parser: byte input and result output.
// Depends on nothing; payload widths follow the parser's field list.
`timescale 1ns / 1ps

interface tlvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [63:0] block_tag;
  logic [63:0]        block_length;
  logic [31:0]        payload_offset;
  logic               final_result;

  modport source (output valid, output event_kind, output block_tag, output block_length,
                  output payload_offset, output final_result, input ready);
  modport sink   (input valid, input event_kind, input block_tag, input block_length,
                  input payload_offset, input final_result, output ready);
endinterface

[src/tlvp_result_queue.sv]
// Small result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on tlvp_pkg.
`timescale 1ns / 1ps

module tlvp_result_queue
  import tlvp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rq_push_t push_i,
  output logic     room_o,    // space for two more results
  output logic     valid_o,
  input  logic     ready_i,
  output res_t     head_o
);

  res_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_AW:0]   count_q, count_d;
  logic             pop;
  logic [RQ_AW-1:0] wr_next;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room_o  = (count_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign wr_next = wr_ptr_q + RQ_AW'(1);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + RQ_AW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + RQ_AW'(pop);
    count_d  = count_q + (RQ_AW+1)'(push_i.cnt) - (RQ_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage: payload only, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("result queue push without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (RQ_AW+1)'(RQ_DEPTH))
    else $error("result queue count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd0 && !pop) |=> $stable(count_q))
    else $error("result queue count moved without push or pop");

endmodule

[src/tlv_block_stream_parser_core.sv]
// Top level of the TLV block parser: header check, tag/length assembly, payload
// counting and status generation. Depends on tlvp_pkg, tlvp_if, tlvp_result_queue.
//
//   channel | dir | payload                                            | transfer when
//   in_i    | in  | data_byte[7:0], last_byte                          | valid & ready
//   out_o   | out | event_kind[1:0], block_tag[63:0], block_length[63:0],| valid & ready
//           |     | payload_offset[31:0], final_result                 |
//
// One byte is taken per cycle while the queue has room; its results are written to
// the result queue at the same edge and can leave on the next cycle. A final byte
// that closes a block gives two results, which drain one per cycle, while out_o.ready
// is high, through the four-entry result queue. in_i.ready drops only while the queue
// holds more than two results. rst_ni clears all parser state and the queue; the
// parser also returns to its reset state by itself after each final byte.
`timescale 1ns / 1ps

module tlv_block_stream_parser_core
  import tlvp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  tlvp_in_if.sink    in_i,
  tlvp_out_if.source out_o
);

  phase_e              phase_q, phase_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [63:0]         tag_q, tag_d;
  logic [63:0]         len_q, len_d;
  logic [63:0]         rem_q, rem_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] saved_q, saved_d;
  logic [1:0]          err_q, err_d;
  logic                past_q, past_d;

  logic     in_fire;
  logic     room;
  logic     blk_valid;
  res_t     blk_res;
  res_t     stat_res;
  rq_push_t push;
  res_t     head;
  logic [5:0] byte_sel;
  logic [63:0] len_full;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = room;
  assign byte_sel   = {cnt_q, 3'b000};

  // Length word with the current byte merged in
  always_comb begin
    len_full = len_q;
    len_full[byte_sel +: 8] = len_q[byte_sel +: 8] | in_i.data_byte;
  end

  // Next state and results for the byte at the input
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    len_d     = len_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    saved_d   = saved_q;
    err_d     = err_q;
    past_d    = past_q;
    blk_valid = 1'b0;
    blk_res   = '0;
    stat_res  = '0;

    if (in_fire) begin
      if (phase_q != PH_SKIP && past_q) begin
        err_d   = EV_TRUNC;
        phase_d = PH_SKIP;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (pos_q < POS_BITS'(MAGIC_BYTES) &&
                in_i.data_byte != MAGIC[pos_q[3:0]]) begin
              err_d   = EV_HEADER;
              phase_d = PH_SKIP;
            end else if (pos_q >= POS_BITS'(HEADER_BYTES - 1)) begin
              phase_d = PH_TAG;
              cnt_d   = '0;
              tag_d   = '0;
            end
          end
          PH_TAG: begin
            tag_d[byte_sel +: 8] = tag_q[byte_sel +: 8] | in_i.data_byte;
            cnt_d = cnt_q + 3'd1;
            if (cnt_q == 3'd7) begin
              len_d   = '0;
              phase_d = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            len_d = len_full;
            cnt_d = cnt_q + 3'd1;
            if (cnt_q == 3'd7) begin
              if (pos_q == '1) begin
                err_d   = EV_TRUNC;
                phase_d = PH_SKIP;
              end else if (len_full == '0) begin
                // zero-length block completes at once
                blk_valid      = 1'b1;
                blk_res.kind   = EV_BLOCK;
                blk_res.tag    = tag_q;
                blk_res.offset = OFFSET_BITS'(pos_q + POS_BITS'(1));
                tag_d          = '0;
                phase_d        = PH_TAG;
              end else begin
                saved_d = pos_q + POS_BITS'(1);
                rem_d   = len_full;
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            rem_d = rem_q - 64'd1;
            if (rem_q == 64'd1) begin
              blk_valid      = 1'b1;
              blk_res.kind   = EV_BLOCK;
              blk_res.tag    = tag_q;
              blk_res.length = len_q;
              blk_res.offset = OFFSET_BITS'(saved_q);
              tag_d          = '0;
              cnt_d          = '0;
              phase_d        = PH_TAG;
            end
          end
          default: begin
          end
        endcase
      end

      // Position counter saturates and flags overflow
      if (pos_q == '1) begin
        past_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_BITS'(1);
      end

      // Closing status on the final byte, then back to reset state
      if (in_i.last_byte) begin
        stat_res.final_res = 1'b1;
        if (err_d != 2'd0) begin
          stat_res.kind = event_e'(err_d);
        end else if (phase_d == PH_HEADER) begin
          stat_res.kind = EV_HEADER;
        end else if (phase_d == PH_TAG && cnt_d == 3'd0) begin
          stat_res.kind = EV_OK;
        end else begin
          stat_res.kind = EV_TRUNC;
        end
        phase_d = PH_HEADER;
        cnt_d   = '0;
        tag_d   = '0;
        len_d   = '0;
        rem_d   = '0;
        pos_d   = '0;
        saved_d = '0;
        err_d   = '0;
        past_d  = 1'b0;
      end
    end
  end

  // Results into the queue, block result ahead of the status
  always_comb begin
    push.cnt    = 2'(blk_valid) + 2'(in_fire && in_i.last_byte);
    push.first  = blk_valid ? blk_res : stat_res;
    push.second = stat_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      saved_q <= '0;
      err_q   <= '0;
      past_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      saved_q <= saved_d;
      err_q   <= err_d;
      past_q  <= past_d;
    end
  end

  tlvp_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.event_kind     = head.kind;
  assign out_o.block_tag      = head.tag;
  assign out_o.block_length   = head.length;
  assign out_o.payload_offset = head.offset;
  assign out_o.final_result   = head.final_res;

  // Checks
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_byte) |=> (phase_q == PH_HEADER && pos_q == '0 && err_q == 2'd0))
    else $error("parser did not return to header phase after final byte");

  a_error_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != 2'd0) |-> (phase_q == PH_SKIP))
    else $error("error recorded outside skip phase");

  a_status_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.final_result) |->
      (out_o.block_tag == '0 && out_o.block_length == '0 && out_o.payload_offset == '0))
    else $error("status result carries block fields");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != '0))
    else $error("payload phase with nothing left to count");

endmodule

[tb/testbench.sv]
// Self-checking bench for tlv_block_stream_parser_core: byte buffers in, block and status events out.
// Depends on tlvp_pkg and tlvp_if; the expected events come from a behavioral parser model below.
`timescale 1ns / 1ps

module testbench;
  import tlvp_pkg::*;

  localparam int unsigned STIM_BYTES   = 900;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tlvp_in_if  in_if ();
  tlvp_out_if out_if ();

  tlv_block_stream_parser_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_item_t byte_backlog[$];
  logic [7:0] frame_bytes[$];
  res_t       predicted_events[$];

  int unsigned stim_bytes;
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned input_stalls;
  int unsigned results_taken;
  int unsigned block_events;
  int unsigned status_events;
  int unsigned errors;
  int unsigned tx_gap;
  int unsigned rx_wait;
  int unsigned hold_left;
  bit          tx_burst;
  bit          rx_burst;

  // ---------------------------------------------------------------------------
  // Parser tracker: mirrors the header/tag/length/payload walk of the block
  // ---------------------------------------------------------------------------
  phase_e      ps_phase;
  logic [7:0]  ps_field_cnt;
  logic [63:0] ps_tag;
  logic [63:0] ps_len;
  logic [63:0] ps_remaining;
  logic [31:0] ps_pos;
  logic [31:0] ps_saved_off;
  logic        ps_err_set;
  event_e      ps_err_kind;
  logic        ps_wrapped;

  function automatic void reset_tracker();
    ps_phase     = PH_HEADER;
    ps_field_cnt = '0;
    ps_tag       = '0;
    ps_len       = '0;
    ps_remaining = '0;
    ps_pos       = '0;
    ps_saved_off = '0;
    ps_err_set   = 1'b0;
    ps_err_kind  = EV_BLOCK;
    ps_wrapped   = 1'b0;
  endfunction

  function automatic void fail_stream(event_e code);
    ps_err_set  = 1'b1;
    ps_err_kind = code;
    ps_phase    = PH_SKIP;
  endfunction

  function automatic void push_event(event_e kind, logic [63:0] tag, logic [63:0] len,
                                     logic [31:0] off, logic fin);
    res_t ev;
    ev.kind      = kind;
    ev.tag       = tag;
    ev.length    = len;
    ev.offset    = off;
    ev.final_res = fin;
    predicted_events.push_back(ev);
  endfunction

  // Advance the tracker by one accepted byte and queue the events it causes
  function automatic void track_parser(logic [7:0] b, logic lst);
    logic [31:0] at;
    event_e      status;
    at = ps_pos;
    if (ps_phase != PH_SKIP && ps_wrapped) fail_stream(EV_TRUNC);

    case (ps_phase)
      PH_HEADER: begin
        if (at < MAGIC_BYTES && b != MAGIC[at[3:0]]) begin
          fail_stream(EV_HEADER);
        end else if (at >= HEADER_BYTES - 1) begin
          ps_phase     = PH_TAG;
          ps_field_cnt = '0;
          ps_tag       = '0;
        end
      end
      PH_TAG: begin
        ps_tag       = ps_tag | (64'(b) << {ps_field_cnt[2:0], 3'b000});
        ps_field_cnt = ps_field_cnt + 8'd1;
        if (ps_field_cnt >= 8) begin
          ps_field_cnt = '0;
          ps_len       = '0;
          ps_phase     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        ps_len       = ps_len | (64'(b) << {ps_field_cnt[2:0], 3'b000});
        ps_field_cnt = ps_field_cnt + 8'd1;
        if (ps_field_cnt >= 8) begin
          ps_field_cnt = '0;
          if (at == '1) begin
            fail_stream(EV_TRUNC);
          end else if (ps_len == 0) begin
            push_event(EV_BLOCK, ps_tag, '0, at + 32'd1, 1'b0);
            ps_tag   = '0;
            ps_phase = PH_TAG;
          end else begin
            ps_saved_off = at + 32'd1;
            ps_remaining = ps_len;
            ps_phase     = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        ps_remaining = ps_remaining - 64'd1;
        if (ps_remaining == 0) begin
          push_event(EV_BLOCK, ps_tag, ps_len, ps_saved_off, 1'b0);
          ps_tag       = '0;
          ps_field_cnt = '0;
          ps_phase     = PH_TAG;
        end
      end
      default: ;
    endcase

    if (ps_pos == '1) ps_wrapped = 1'b1;
    else ps_pos = ps_pos + 32'd1;

    // Closing status, then back to the start-of-buffer state
    if (lst) begin
      if (ps_err_set) status = ps_err_kind;
      else if (ps_phase == PH_HEADER) status = EV_HEADER;
      else if (ps_phase == PH_TAG && ps_field_cnt == 0) status = EV_OK;
      else status = EV_TRUNC;
      push_event(status, '0, '0, '0, 1'b1);
      reset_tracker();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Buffer builders
  // ---------------------------------------------------------------------------
  task automatic add_le64(logic [63:0] v);
    for (int i = 0; i < 8; i++) frame_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_magic();
    for (int i = 0; i < HEADER_BYTES; i++)
      frame_bytes.push_back(i < MAGIC_BYTES ? MAGIC[i] : 8'($urandom));
  endtask

  task automatic add_block(logic [63:0] tag, logic [63:0] len, int unsigned payload_cnt);
    add_le64(tag);
    add_le64(len);
    for (int unsigned i = 0; i < payload_cnt; i++) frame_bytes.push_back(8'($urandom));
  endtask

  // Header plus a few complete blocks with random content
  task automatic build_good_frame(int unsigned n_blocks);
    logic [63:0] tag;
    logic [63:0] len;
    add_magic();
    for (int unsigned k = 0; k < n_blocks; k++) begin
      case ($urandom_range(0, 7))
        0:       tag = 64'h8000_0000_0000_0000;
        1:       tag = 64'h7fff_ffff_ffff_ffff;
        2:       tag = '0;
        3:       tag = '1;
        default: tag = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = 64'($urandom_range(13, 60));
        default: len = 64'($urandom_range(1, 12));
      endcase
      add_block(tag, len, len);
    end
  endtask

  // Move the frame into the send backlog; last marks the final byte
  task automatic flush_frame(int unsigned live);
    byte_item_t it;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.data = frame_bytes[i];
      it.last = (i == frame_bytes.size() - 1);
      byte_backlog.push_back(it);
    end
    stim_bytes += live;
    frame_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: one item from the backlog per transfer, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver_p
    byte_item_t nxt;
    logic       busy;
    if (rst_n) begin
      busy = in_if.valid;
      if (in_if.valid && !in_if.ready) input_stalls++;
      if (in_if.valid && in_if.ready) begin
        track_parser(in_if.data_byte, in_if.last_byte);
        bytes_sent++;
        if (in_if.last_byte) buffers_sent++;
        busy = 1'b0;
        if (bytes_sent % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        tx_gap = tx_burst ? 0 : $urandom_range(0, 18);
      end
      if (!busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (byte_backlog.size() != 0) begin
          nxt = byte_backlog.pop_front();
          in_if.data_byte <= nxt.data;
          in_if.last_byte <= nxt.last;
          busy = 1'b1;
        end
      end
      in_if.valid <= busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side ready: random waits per transfer, two long hold-offs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_ready_p
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_taken++;
        if (results_taken % 32 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        rx_wait = rx_burst ? 0 : $urandom_range(0, 18);
        // long stall so the result queue fills and the byte input backs up
        if (results_taken == 10 || results_taken == 50) hold_left = HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left--;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_if.ready <= (hold_left == 0) && (rx_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Event checker: each transfer against the oldest predicted event
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : event_check_p
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_events.size() == 0) begin
        $error("unexpected event: event_kind %0d", out_if.event_kind);
        errors++;
      end else begin
        want = predicted_events.pop_front();
        if (want.final_res) status_events++;
        else block_events++;
        if (out_if.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_if.event_kind);
          errors++;
        end
        if (out_if.block_tag !== want.tag) begin
          $error("block_tag: expected %0d, got %0d", want.tag, out_if.block_tag);
          errors++;
        end
        if (out_if.block_length !== want.length) begin
          $error("block_length: expected %0d, got %0d", want.length, out_if.block_length);
          errors++;
        end
        if (out_if.payload_offset !== want.offset) begin
          $error("payload_offset: expected %0d, got %0d", want.offset,
                 out_if.payload_offset);
          errors++;
        end
        if (out_if.final_result !== want.final_res) begin
          $error("final_result: expected %0d, got %0d", want.final_res,
                 out_if.final_result);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_p
    int unsigned kind;
    int unsigned cut;
    int unsigned bad_at;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    reset_tracker();

    // Directed: bad first byte, short header, block closed by the final byte
    frame_bytes.push_back(8'hff);
    flush_frame(1);
    frame_bytes.push_back(MAGIC[0]);
    flush_frame(1);
    add_magic();
    add_block(64'h8000_0000_0000_0000, 64'd0, 0);
    flush_frame(frame_bytes.size());
    // huge length, buffer ends inside the payload
    add_magic();
    add_block(64'h7fff_ffff_ffff_ffff, '1, 1);
    flush_frame(frame_bytes.size());
    // one block, then the buffer ends in the middle of the next tag
    add_magic();
    add_block(64'd1, 64'd2, 0);
    frame_bytes.push_back(8'hff);
    frame_bytes.push_back(8'h00);
    for (int i = 0; i < 3; i++) frame_bytes.push_back(8'($urandom));
    flush_frame(frame_bytes.size());
    // mismatch inside the magic, trailing bytes ignored
    frame_bytes.push_back(MAGIC[0]);
    frame_bytes.push_back(MAGIC[1]);
    frame_bytes.push_back(8'h00);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(8'($urandom));
    flush_frame(3);
    // header alone is a clean buffer; cut inside a length field
    add_magic();
    flush_frame(frame_bytes.size());
    add_magic();
    add_le64(64'd5);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(8'($urandom));
    flush_frame(frame_bytes.size());

    // Random buffers, mostly well formed
    while (stim_bytes < STIM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        build_good_frame($urandom_range(0, 4));
        flush_frame(frame_bytes.size());
      end else if (kind < 80) begin
        build_good_frame($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0)
          add_block({$urandom, $urandom}, {$urandom | 32'h1, $urandom}, $urandom_range(0, 5));
        cut = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        flush_frame(frame_bytes.size());
      end else if (kind < 92) begin
        build_good_frame($urandom_range(0, 2));
        bad_at = $urandom_range(0, MAGIC_BYTES - 1);
        frame_bytes[bad_at] = frame_bytes[bad_at] ^ 8'($urandom_range(1, 255));
        flush_frame(bad_at + 1);
      end else begin
        repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
        flush_frame(frame_bytes.size());
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_backlog.size() != 0 || in_if.valid || predicted_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes in %0d buffers; input stalled %0d cycles under back-pressure.",
             bytes_sent, buffers_sent, input_stalls);
    $display("Checked %0d block events and %0d closing status events.",
             block_events, status_events);
    if (errors == 0 && predicted_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $error("timeout: %0d events still expected", predicted_events.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[tlv_block_stream_parser_core.f]
src/tlvp_pkg.sv
src/tlvp_if.sv
src/tlvp_result_queue.sv
src/tlv_block_stream_parser_core.sv
tb/testbench.sv
